// ===== hw/rtl/mrsr_pkg.sv =====
// Shared types, constants and microcode table for the matrix row shift and rotate unit.
`default_nettype none

package mrsr_pkg;

  localparam int MAX_N_DEF = 8;
  localparam int DATA_W    = 32;
  localparam int SIZE_W    = 4;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  // register index of size_in_use
  localparam logic [2:0] REG_SIZE_ADDR = 3'd0;

  localparam int STEP_W = 5;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SHIFT  = 2'd1,
    CMD_ROTATE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {RA_IN, RA_IJ, RA_ROWJ} ra_sel_t;
  typedef enum logic [1:0] {WA_IN, WA_ROWJ, WA_Q} wa_sel_t;
  typedef enum logic [1:0] {WAL_HOLD, WAL_ROT, WAL_IJ} wal_sel_t;
  typedef enum logic [1:0] {WD_VALUE, WD_CARRY, WD_STQ, WD_SCQ} wd_sel_t;
  typedef enum logic [1:0] {CNT_HOLD, CNT_CLR, CNT_JLAST, CNT_STEP} cnt_op_t;
  typedef enum logic [3:0] {
    C_NONE, C_ALWAYS, C_DISPATCH, C_OOR_RC, C_OOR_R, C_OUT_BUSY,
    C_J_MORE, C_IJ_MORE, C_IJ_LAST
  } cond_t;

  // program steps
  localparam logic [STEP_W-1:0] S_IDLE   = 5'd0;
  localparam logic [STEP_W-1:0] S_LD     = 5'd1;
  localparam logic [STEP_W-1:0] S_LD_W   = 5'd2;
  localparam logic [STEP_W-1:0] S_RD     = 5'd3;
  localparam logic [STEP_W-1:0] S_RD_R   = 5'd4;
  localparam logic [STEP_W-1:0] S_RD_O   = 5'd5;
  localparam logic [STEP_W-1:0] S_RD_X   = 5'd6;
  localparam logic [STEP_W-1:0] S_SH     = 5'd7;
  localparam logic [STEP_W-1:0] S_SH_L   = 5'd8;
  localparam logic [STEP_W-1:0] S_SH_C   = 5'd9;
  localparam logic [STEP_W-1:0] S_SH_R   = 5'd10;
  localparam logic [STEP_W-1:0] S_SH_W   = 5'd11;
  localparam logic [STEP_W-1:0] S_SH_X   = 5'd12;
  localparam logic [STEP_W-1:0] S_RO     = 5'd13;
  localparam logic [STEP_W-1:0] S_RO_L   = 5'd14;
  localparam logic [STEP_W-1:0] S_RO_E   = 5'd15;
  localparam logic [STEP_W-1:0] S_CP     = 5'd16;
  localparam logic [STEP_W-1:0] S_CP_L   = 5'd17;
  localparam logic [STEP_W-1:0] S_CP_E   = 5'd18;

  typedef struct packed {
    logic                st_rd;
    logic                sc_rd;
    logic                st_wr;
    logic                sc_wr;
    ra_sel_t             ra;
    wa_sel_t             wa;
    wal_sel_t            wal;
    wd_sel_t             wd;
    logic                carry_ld;
    logic                out_ld;
    cnt_op_t             cnt;
    cond_t               cond;
    logic [STEP_W-1:0]   target;
  } ucode_t;

  typedef struct packed {
    logic oor_rc;
    logic oor_r;
    logic j_last;
    logic ij_last;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [STEP_W-1:0] cmd_entry(input cmd_t cmd);
    logic [STEP_W-1:0] s;
    unique case (cmd)
      CMD_LOAD:   s = S_LD;
      CMD_SHIFT:  s = S_SH;
      CMD_ROTATE: s = S_RO;
      CMD_READ:   s = S_RD;
      default:    s = S_IDLE;
    endcase
    return s;
  endfunction

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '0;
    unique case (step)
      S_IDLE: begin
        w.cnt  = CNT_CLR;
        w.cond = C_DISPATCH;
      end
      S_LD: begin
        w.cond = C_OOR_RC; w.target = S_IDLE;
      end
      S_LD_W: begin
        w.st_wr = 1'b1; w.wa = WA_IN; w.wd = WD_VALUE;
        w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      S_RD: begin
        w.cond = C_OOR_RC; w.target = S_IDLE;
      end
      S_RD_R: begin
        w.st_rd = 1'b1; w.ra = RA_IN;
      end
      S_RD_O: begin
        w.out_ld = 1'b1;
        w.cond = C_OUT_BUSY; w.target = S_RD_O;
      end
      S_RD_X: begin
        w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      S_SH: begin
        w.cnt = CNT_JLAST;
        w.cond = C_OOR_R; w.target = S_IDLE;
      end
      S_SH_L: begin
        w.st_rd = 1'b1; w.ra = RA_ROWJ; w.cnt = CNT_CLR;
      end
      S_SH_C: begin
        w.carry_ld = 1'b1;
      end
      S_SH_R: begin
        w.st_rd = 1'b1; w.ra = RA_ROWJ;
      end
      S_SH_W: begin
        // write the carried word, pick up the one it replaces
        w.st_wr = 1'b1; w.wa = WA_ROWJ; w.wd = WD_CARRY; w.carry_ld = 1'b1;
        w.cnt = CNT_STEP; w.cond = C_J_MORE; w.target = S_SH_R;
      end
      S_SH_X: begin
        w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      S_RO: begin
        w.st_rd = 1'b1; w.ra = RA_IJ; w.wal = WAL_ROT; w.cnt = CNT_STEP;
        w.cond = C_IJ_LAST; w.target = S_RO_E;
      end
      S_RO_L: begin
        // store the previous element while fetching the next
        w.sc_wr = 1'b1; w.wa = WA_Q; w.wd = WD_STQ;
        w.st_rd = 1'b1; w.ra = RA_IJ; w.wal = WAL_ROT; w.cnt = CNT_STEP;
        w.cond = C_IJ_MORE; w.target = S_RO_L;
      end
      S_RO_E: begin
        w.sc_wr = 1'b1; w.wa = WA_Q; w.wd = WD_STQ; w.cnt = CNT_CLR;
      end
      S_CP: begin
        w.sc_rd = 1'b1; w.ra = RA_IJ; w.wal = WAL_IJ; w.cnt = CNT_STEP;
        w.cond = C_IJ_LAST; w.target = S_CP_E;
      end
      S_CP_L: begin
        w.st_wr = 1'b1; w.wa = WA_Q; w.wd = WD_SCQ;
        w.sc_rd = 1'b1; w.ra = RA_IJ; w.wal = WAL_IJ; w.cnt = CNT_STEP;
        w.cond = C_IJ_MORE; w.target = S_CP_L;
      end
      S_CP_E: begin
        w.st_wr = 1'b1; w.wa = WA_Q; w.wd = WD_SCQ;
        w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mrsr_useq.sv =====
// Microcode sequencer: step counter, control word fetch and branch decision.
`default_nettype none

module mrsr_useq (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [1:0]                  cmd,
  input  wire mrsr_pkg::dp_stat_t          stat,
  output mrsr_pkg::ucode_t                 ctl,
  output logic                             in_ready
);

  logic [mrsr_pkg::STEP_W-1:0] upc;
  logic [mrsr_pkg::STEP_W-1:0] upc_next;
  logic                        taken;

  assign ctl      = mrsr_pkg::ucode_rom(upc);
  assign in_ready = (upc == mrsr_pkg::S_IDLE);

  always_comb begin
    unique case (ctl.cond)
      mrsr_pkg::C_NONE:     taken = 1'b0;
      mrsr_pkg::C_ALWAYS:   taken = 1'b1;
      mrsr_pkg::C_DISPATCH: taken = in_valid;
      mrsr_pkg::C_OOR_RC:   taken = stat.oor_rc;
      mrsr_pkg::C_OOR_R:    taken = stat.oor_r;
      mrsr_pkg::C_OUT_BUSY: taken = stat.out_busy;
      mrsr_pkg::C_J_MORE:   taken = !stat.j_last;
      mrsr_pkg::C_IJ_MORE:  taken = !stat.ij_last;
      mrsr_pkg::C_IJ_LAST:  taken = stat.ij_last;
      default:              taken = 1'b0;
    endcase
  end

  always_comb begin
    priority if (ctl.cond == mrsr_pkg::C_DISPATCH) begin
      upc_next = taken ? mrsr_pkg::cmd_entry(mrsr_pkg::cmd_t'(cmd)) : upc;
    end else if (taken) begin
      upc_next = ctl.target;
    end else begin
      upc_next = upc + mrsr_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= mrsr_pkg::S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mrsr_dpath.sv =====
// Datapath: item registers, index counters, matrix and scratch memories, output register.
`default_nettype none

module mrsr_dpath #(
  parameter int MAX_N = mrsr_pkg::MAX_N_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [mrsr_pkg::SIZE_W-1:0]       size_in_use,
  input  wire logic                              in_fire,
  input  wire logic [2:0]                        row_index,
  input  wire logic [2:0]                        col_index,
  input  wire logic [mrsr_pkg::DATA_W-1:0]       value,
  input  wire mrsr_pkg::ucode_t                  ctl,
  input  wire logic                              out_ready,
  output mrsr_pkg::dp_stat_t                     stat,
  output logic                                   out_valid,
  output logic [mrsr_pkg::DATA_W-1:0]            element
);

  localparam int NW    = $clog2(MAX_N + 1);
  localparam int IW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int DEPTH = MAX_N * MAX_N;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMPW  = (NW > mrsr_pkg::SIZE_W) ? NW : mrsr_pkg::SIZE_W;

  logic [NW-1:0]   n;
  logic [IW-1:0]   nm1;
  logic [CMPW-1:0] size_x;

  logic [2:0]                  row_q;
  logic [2:0]                  col_q;
  logic [mrsr_pkg::DATA_W-1:0] value_q;
  logic [IW-1:0]               row_i;
  logic [IW-1:0]               col_i;

  logic [IW-1:0] i;
  logic [IW-1:0] j;
  logic          j_last;

  logic [AW-1:0] addr_in;
  logic [AW-1:0] addr_ij;
  logic [AW-1:0] addr_rowj;
  logic [AW-1:0] addr_rot;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] wa_q;

  logic [mrsr_pkg::DATA_W-1:0] wr_data;
  logic [mrsr_pkg::DATA_W-1:0] st_q;
  logic [mrsr_pkg::DATA_W-1:0] sc_q;
  logic [mrsr_pkg::DATA_W-1:0] carry;

  logic [mrsr_pkg::DATA_W-1:0] store_mem   [DEPTH];
  logic [mrsr_pkg::DATA_W-1:0] scratch_mem [DEPTH];

  logic out_busy;

  // clamp the side: zero acts as one, anything above MAX_N as MAX_N
  assign size_x = CMPW'(size_in_use);
  always_comb begin
    priority if (size_in_use == '0) begin
      n = NW'(1);
    end else if (size_x > CMPW'(MAX_N)) begin
      n = NW'(MAX_N);
    end else begin
      n = NW'(size_x);
    end
  end
  assign nm1 = IW'(n - NW'(1));

  always_ff @(posedge clk) begin
    if (in_fire) begin
      row_q   <= row_index;
      col_q   <= col_index;
      value_q <= value;
    end
  end

  assign row_i = IW'(row_q);
  assign col_i = IW'(col_q);

  assign j_last        = (j == nm1);
  assign out_busy      = out_valid && !out_ready;
  assign stat.oor_r    = (CMPW'(row_q) >= CMPW'(n));
  assign stat.oor_rc   = stat.oor_r || (CMPW'(col_q) >= CMPW'(n));
  assign stat.j_last   = j_last;
  assign stat.ij_last  = j_last && (i == nm1);
  assign stat.out_busy = out_busy;

  // walk i over rows, j over columns
  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
      j <= '0;
    end else begin
      unique case (ctl.cnt)
        mrsr_pkg::CNT_HOLD: ;
        mrsr_pkg::CNT_CLR: begin
          i <= '0;
          j <= '0;
        end
        mrsr_pkg::CNT_JLAST: j <= nm1;
        mrsr_pkg::CNT_STEP: begin
          if (j_last) begin
            j <= '0;
            i <= i + IW'(1);
          end else begin
            j <= j + IW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign addr_in   = AW'(row_i) * AW'(MAX_N) + AW'(col_i);
  assign addr_ij   = AW'(i) * AW'(MAX_N) + AW'(j);
  assign addr_rowj = AW'(row_i) * AW'(MAX_N) + AW'(j);
  // clockwise: element (i, j) lands at (j, n-1-i)
  assign addr_rot  = AW'(j) * AW'(MAX_N) + AW'(IW'(nm1 - i));

  always_comb begin
    unique case (ctl.ra)
      mrsr_pkg::RA_IN:   rd_addr = addr_in;
      mrsr_pkg::RA_IJ:   rd_addr = addr_ij;
      mrsr_pkg::RA_ROWJ: rd_addr = addr_rowj;
      default:           rd_addr = addr_in;
    endcase
  end

  always_comb begin
    unique case (ctl.wa)
      mrsr_pkg::WA_IN:   wr_addr = addr_in;
      mrsr_pkg::WA_ROWJ: wr_addr = addr_rowj;
      mrsr_pkg::WA_Q:    wr_addr = wa_q;
      default:           wr_addr = addr_in;
    endcase
  end

  always_comb begin
    unique case (ctl.wd)
      mrsr_pkg::WD_VALUE: wr_data = value_q;
      mrsr_pkg::WD_CARRY: wr_data = carry;
      mrsr_pkg::WD_STQ:   wr_data = st_q;
      mrsr_pkg::WD_SCQ:   wr_data = sc_q;
      default:            wr_data = value_q;
    endcase
  end

  // hold the write address of the element in flight
  always_ff @(posedge clk) begin
    unique case (ctl.wal)
      mrsr_pkg::WAL_HOLD: ;
      mrsr_pkg::WAL_ROT:  wa_q <= addr_rot;
      mrsr_pkg::WAL_IJ:   wa_q <= addr_ij;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.st_wr) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (ctl.st_rd) begin
      st_q <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sc_wr) begin
      scratch_mem[wr_addr] <= wr_data;
    end
    if (ctl.sc_rd) begin
      sc_q <= scratch_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.carry_ld) begin
      carry <= st_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_ld && !out_busy) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_ld && !out_busy) begin
      element <= st_q;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/matrix_row_shift_and_rotate_unit.sv =====
// Top level: configuration register, sequencer and datapath of the matrix shift and rotate unit.
// One item at a time; in_ready is high only while the sequencer sits at its idle step.
// Load checks the indices, then writes; read checks, reads, then loads the result and waits while
// the output is held; shift checks the row; an index out of range sends the sequencer to idle.
// Rotate moves one word per cycle through each memory's single write port: to scratch, then back.
// Reset clears the sequencer and out_valid and sets size_in_use to 8; no clearing pass.
`default_nettype none

module matrix_row_shift_and_rotate_unit #(
  parameter int MAX_N = mrsr_pkg::MAX_N_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         cmd,
  input  wire logic [2:0]         row_index,
  input  wire logic [2:0]         col_index,
  input  wire logic signed [31:0] value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      element
);

  logic [mrsr_pkg::SIZE_W-1:0] size_in_use;
  logic                        reg_sel;
  logic                        in_fire;
  mrsr_pkg::ucode_t            ctl;
  mrsr_pkg::dp_stat_t          stat;
  logic [mrsr_pkg::DATA_W-1:0] element_raw;

  assign pready  = 1'b1;
  assign reg_sel = (paddr == mrsr_pkg::REG_SIZE_ADDR);
  assign prdata  = reg_sel ? {{(32 - mrsr_pkg::SIZE_W){1'b0}}, size_in_use} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= mrsr_pkg::SIZE_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      size_in_use <= pwdata[mrsr_pkg::SIZE_W-1:0];
    end
  end

  assign in_fire = in_valid && in_ready;
  assign element = $signed(element_raw);

  mrsr_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .stat     (stat),
    .ctl      (ctl),
    .in_ready (in_ready)
  );

  mrsr_dpath #(
    .MAX_N (MAX_N)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .size_in_use (size_in_use),
    .in_fire     (in_fire),
    .row_index   (row_index),
    .col_index   (col_index),
    .value       ($unsigned(value)),
    .ctl         (ctl),
    .out_ready   (out_ready),
    .stat        (stat),
    .out_valid   (out_valid),
    .element     (element_raw)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/mrsr_chk.sv =====
// Port-level checker for the matrix shift and rotate unit, bound to the top level.
`default_nettype none

module mrsr_chk (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [31:0] element
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(element))
    else $error("result changed while held");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second item while busy");

  // a new result only comes out of a command in progress
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while idle");

  // leave reset idle with no result pending
  a_reset_state: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("bad state after reset");

endmodule

bind matrix_row_shift_and_rotate_unit mrsr_chk u_mrsr_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .element   (element)
);

`default_nettype wire

// ===== test/matrix_row_shift_and_rotate_unit_tb.sv =====
// Testbench for the matrix row shift and rotate unit: directed table, then random phases.
`timescale 1ns / 1ps

module matrix_row_shift_and_rotate_unit_tb;

  localparam int LIMIT = 1_200_000;
  localparam int N_MAX = mrsr_pkg::MAX_N_DEF;
  localparam int RANDOM_ITEMS = 1800;
  localparam int PHASE_ITEMS = 130;
  localparam int DRAIN_PAUSE = 200;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AFTER = 60;
  localparam logic [2:0] SIZE_BYTE_ADDR = 3'(4 * mrsr_pkg::REG_SIZE_ADDR);

  typedef struct packed {
    mrsr_pkg::cmd_t op;
    logic [2:0]     r;
    logic [2:0]     c;
    logic [31:0]    v;
  } mat_item_t;

  typedef enum logic {ROW_ITEM, ROW_SIZE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] size_val;
    mat_item_t   it;
    logic        typed;
    logic [31:0] want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid;
  logic in_ready;
  logic [1:0] cmd;
  logic [2:0] row_index;
  logic [2:0] col_index;
  logic signed [31:0] value;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] element;

  // shadow of the matrix, with a flag for each cell that holds a loaded word
  logic [31:0] mat_cell [N_MAX][N_MAX];
  bit mat_known [N_MAX][N_MAX];
  logic [3:0] side_reg = mrsr_pkg::SIZE_RESET;

  logic [31:0] pending_reads [$];
  dir_row_t dir_tbl [$];
  int bad_count = 0;
  int results_seen = 0;
  int burst_left = 0;

  matrix_row_shift_and_rotate_unit i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .row_index(row_index), .col_index(col_index), .value(value),
    .out_valid(out_valid), .out_ready(out_ready), .element(element)
  );

  always #5 clk = ~clk;

  function automatic int side_len();
    int n;
    n = int'(side_reg);
    if (n < 1) n = 1;
    if (n > N_MAX) n = N_MAX;
    return n;
  endfunction

  task automatic matrix_apply(input mat_item_t it, output bit hit, output logic [31:0] word);
    logic [31:0] tc [N_MAX][N_MAX];
    bit tk [N_MAX][N_MAX];
    logic [31:0] last_c;
    bit last_k;
    int n;
    n = side_len();
    hit = 1'b0;
    word = '0;
    case (it.op)
      mrsr_pkg::CMD_LOAD: begin
        if (it.r < n && it.c < n) begin
          mat_cell[it.r][it.c] = it.v;
          mat_known[it.r][it.c] = 1'b1;
        end
      end
      mrsr_pkg::CMD_SHIFT: begin
        if (it.r < n) begin
          last_c = mat_cell[it.r][n-1];
          last_k = mat_known[it.r][n-1];
          for (int k = n - 1; k > 0; k--) begin
            mat_cell[it.r][k] = mat_cell[it.r][k-1];
            mat_known[it.r][k] = mat_known[it.r][k-1];
          end
          mat_cell[it.r][0] = last_c;
          mat_known[it.r][0] = last_k;
        end
      end
      mrsr_pkg::CMD_ROTATE: begin
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++) begin
            tc[j][n-1-i] = mat_cell[i][j];
            tk[j][n-1-i] = mat_known[i][j];
          end
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++) begin
            mat_cell[i][j] = tc[i][j];
            mat_known[i][j] = tk[i][j];
          end
      end
      default: begin
        if (it.r < n && it.c < n) begin
          hit = 1'b1;
          word = mat_cell[it.r][it.c];
        end
      end
    endcase
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // turn a read of a never-loaded cell into a load of that cell
  function automatic mat_item_t avoid_blank_read(mat_item_t it);
    int n;
    n = side_len();
    if (it.op == mrsr_pkg::CMD_READ && it.r < n && it.c < n && !mat_known[it.r][it.c]) begin
      it.op = mrsr_pkg::CMD_LOAD;
      it.v = rand_word();
    end
    return it;
  endfunction

  function automatic bit takes_effect(mat_item_t it);
    int n;
    n = side_len();
    if (it.op == mrsr_pkg::CMD_ROTATE) return 1'b1;
    if (it.op == mrsr_pkg::CMD_SHIFT) return it.r < n;
    return it.r < n && it.c < n;
  endfunction

  function automatic dir_row_t ld(int r, int c, logic [31:0] v);
    return '{ROW_ITEM, 32'd0, '{mrsr_pkg::CMD_LOAD, 3'(r), 3'(c), v}, 1'b0, 32'd0};
  endfunction

  function automatic dir_row_t rd(int r, int c);
    return '{ROW_ITEM, 32'd0, '{mrsr_pkg::CMD_READ, 3'(r), 3'(c), 32'd0}, 1'b0, 32'd0};
  endfunction

  function automatic dir_row_t rdk(int r, int c, logic [31:0] want);
    return '{ROW_ITEM, 32'd0, '{mrsr_pkg::CMD_READ, 3'(r), 3'(c), 32'd0}, 1'b1, want};
  endfunction

  function automatic dir_row_t sh(int r, int c, logic [31:0] v);
    return '{ROW_ITEM, 32'd0, '{mrsr_pkg::CMD_SHIFT, 3'(r), 3'(c), v}, 1'b0, 32'd0};
  endfunction

  function automatic dir_row_t rot(int r, int c, logic [31:0] v);
    return '{ROW_ITEM, 32'd0, '{mrsr_pkg::CMD_ROTATE, 3'(r), 3'(c), v}, 1'b0, 32'd0};
  endfunction

  function automatic dir_row_t sz(logic [31:0] d);
    return '{ROW_SIZE, d, '{mrsr_pkg::CMD_LOAD, 3'd0, 3'd0, 32'd0}, 1'b0, 32'd0};
  endfunction

  task automatic send_item(input mat_item_t it, input bit typed, input logic [31:0] want);
    int gap;
    bit hit;
    logic [31:0] word;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    cmd <= it.op;
    row_index <= it.r;
    col_index <= it.c;
    value <= it.v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    matrix_apply(it, hit, word);
    if (hit) pending_reads.push_back(typed ? want : word);
  endtask

  task automatic wait_drained();
    while (pending_reads.size() != 0) @(posedge clk);
  endtask

  task automatic set_size(input logic [31:0] d);
    in_valid <= 1'b0;
    wait_drained();
    // let a rotate or shift with no result finish before touching the size
    repeat (DRAIN_PAUSE) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SIZE_BYTE_ADDR;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    side_reg = d[3:0];
    burst_left = 0;
  endtask

  // check each read result against the oldest expected element
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_reads.size() == 0) begin
        if (bad_count < 10) $display("read result with none expected: got %h", element);
        bad_count++;
      end else begin
        want = pending_reads.pop_front();
        if (element !== want) begin
          if (bad_count < 10)
            $display("read result %0d: expected %h, got %h", results_seen, want, element);
          bad_count++;
        end
      end
    end
  end

  // receiver: stall in changing patterns, with one long hold-off
  initial begin
    int mode;
    int span;
    bit held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 120);
      repeat (span) begin
        if (!held && results_seen >= HOLD_AFTER) begin
          held = 1'b1;
          out_ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("matrix_row_shift_and_rotate_unit: mismatch");
    $finish;
  end

  initial begin
    int sizes [$];
    int total;
    int count;
    int ph;
    int n;
    int sel;
    logic [3:0] sz_pick;
    mat_item_t it;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    cmd = mrsr_pkg::CMD_LOAD;
    row_index = '0;
    col_index = '0;
    value = '0;
    out_ready = 1'b0;
    sizes = '{1, 8, 0, 15, 4};

    dir_tbl = '{
      ld(0, 0, 32'h8000_0000), ld(7, 7, 32'h7fff_ffff),
      ld(0, 7, 32'hffff_ffff), ld(7, 0, 32'h0000_0000),
      rdk(0, 0, 32'h8000_0000), rdk(7, 7, 32'h7fff_ffff),
      rdk(0, 7, 32'hffff_ffff), rdk(7, 0, 32'h0000_0000),
      sh(0, 5, 32'haaaa_5555), rd(0, 0), rd(0, 1),
      sz(32'd2),
      ld(0, 0, 32'd1), ld(0, 1, 32'd2), ld(1, 0, 32'd3), ld(1, 1, 32'd4),
      rot(7, 7, 32'h5a5a_5a5a), rd(0, 0), rd(0, 1), rd(1, 1),
      ld(0, 2, 32'h1234_5678), rd(2, 0), sh(2, 0, 32'd0),
      sz(32'd0),
      rot(3, 4, 32'hffff_ffff), rd(0, 0), rd(0, 1),
      sz(32'h0000_001f),
      rdk(7, 7, 32'h7fff_ffff), rdk(7, 0, 32'h0000_0000)
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[k]) begin
      if (dir_tbl[k].kind == ROW_SIZE) set_size(dir_tbl[k].size_val);
      else send_item(dir_tbl[k].it, dir_tbl[k].typed, dir_tbl[k].want);
    end

    total = 0;
    ph = 0;
    while (total < RANDOM_ITEMS) begin
      sz_pick = (ph < sizes.size()) ? 4'(sizes[ph]) : 4'($urandom_range(0, 15));
      set_size({28'($urandom()), sz_pick});
      n = side_len();
      count = 0;
      // fill most of the matrix first so reads and rotates see loaded words
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++)
          if ($urandom_range(0, 7) != 0) begin
            send_item('{mrsr_pkg::CMD_LOAD, 3'(r), 3'(c), rand_word()}, 1'b0, '0);
            count++;
          end
      while (count < PHASE_ITEMS) begin
        sel = $urandom_range(0, 99);
        it.r = 3'($urandom_range(0, n - 1));
        it.c = 3'($urandom_range(0, n - 1));
        it.v = rand_word();
        if (sel < 30) it.op = mrsr_pkg::CMD_LOAD;
        else if (sel < 65) it.op = mrsr_pkg::CMD_READ;
        else if (sel < 80) it.op = mrsr_pkg::CMD_SHIFT;
        else if (sel < 88) it.op = mrsr_pkg::CMD_ROTATE;
        else begin
          it.op = mrsr_pkg::cmd_t'($urandom_range(0, 3));
          it.r = 3'($urandom_range(0, 7));
          it.c = 3'($urandom_range(0, 7));
        end
        it = avoid_blank_read(it);
        if (takes_effect(it)) count++;
        send_item(it, 1'b0, '0);
      end
      total += count;
      ph++;
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_PAUSE) @(posedge clk);
    bad_count += pending_reads.size();
    if (bad_count == 0) begin
      $display("matrix_row_shift_and_rotate_unit: match");
    end else begin
      $display("matrix_row_shift_and_rotate_unit: mismatch");
    end
    $finish;
  end

endmodule
